[rtl/hbsd_pkg.sv]
`default_nettype none

package hbsd_pkg;

	localparam int NODE_COUNT = 512;
	localparam int ADDR_W = $clog2(NODE_COUNT);
	localparam int IDX_W = 9;
	localparam int SYM_W = 8;

	localparam logic REQ_NODE_WRITE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] node_addr;
		logic             node_is_leaf;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] right_child;
		logic [SYM_W-1:0] leaf_symbol;
		logic             bit_value;
		logic             last_bit;
	} req_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             status;
	} rsp_t;

	// one node store entry
	typedef struct packed {
		logic             is_leaf;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] sym;
	} node_t;

	// node index to store address (modulo a power-of-two store size)
	function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] idx);
		return ADDR_W'(idx);
	endfunction

endpackage

`default_nettype wire

[rtl/hbsd_ram.sv]
`default_nettype none

module hbsd_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[rtl/huffman_bit_serial_decoder.sv]
// A node write is registered into the store at its beat. A decode result is registered,
// straight from the beat on an already-leaf current node, else from the child read.
// Throughput: 1 per cycle while req_ready is high for node writes and for decode bits on a
// leaf (empty encoding); a child read, addressed by the previous bit, holds off the next bit.
// Reset (arst_n low, async): walk and root at node 0, root/current node caches invalid, no
// result pending; the node store is not cleared; a store read then refills the node cache.
`default_nettype none

module huffman_bit_serial_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [hbsd_pkg::IDX_W-1:0] cfg_wdata,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire hbsd_pkg::req_t             req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output hbsd_pkg::rsp_t                  rsp
);

	import hbsd_pkg::*;

	// Walk state: walk_q is the current node index; cur_q caches that node's
	// entry so each decode bit needs only one store read (the child).
	// root_ent_q caches the root entry so returning to root costs no store read while it is valid.
	logic [IDX_W-1:0]  walk_q;
	logic [IDX_W-1:0]  root_q;
	node_t             cur_q;
	logic              cur_vld_q;
	node_t             root_ent_q;
	logic              root_vld_q;

	// child read in flight (decode stage 1) and cache refill in flight
	logic              pend_s1;
	logic [IDX_W-1:0]  next_s1;
	logic              last_s1;
	logic              fetch_s1;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// store port
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	node_t             rd_data;
	logic [$bits(node_t)-1:0] rd_raw;
	logic              wr_en;
	node_t             new_node;

	logic              is_dec;
	logic              out_free;
	logic              acc;
	logic              dec_acc;
	logic              wr_acc;
	logic              issue;
	logic              fetch;
	logic              fetch_done;
	logic [IDX_W-1:0]  next_idx;
	logic              go_root_now;
	logic              done_leaf;
	logic              to_root;
	logic              step;
	logic              wr_hit_cur;
	logic              wr_hit_root;
	logic              walk_is_root;
	logic              next_is_root;

	always_comb begin
		is_dec   = (req.req_type == REQ_DECODE);
		out_free = !rsp_valid_q || rsp_ready;
		// No beat while the child read resolves or the node cache is refilling;
		// a decode beat also needs the result register free.
		req_ready = cur_vld_q && !pend_s1 && (!is_dec || out_free);
		acc      = req_valid && req_ready;
		dec_acc  = acc && is_dec;
		wr_acc   = acc && !is_dec;

		next_idx = req.bit_value ? cur_q.right : cur_q.left;

		// current node is a leaf: empty encoding right away
		go_root_now = dec_acc && cur_q.is_leaf;
		issue       = dec_acc && !cur_q.is_leaf;

		fetch      = !cur_vld_q && !fetch_s1 && !pend_s1 && !cfg_we;
		fetch_done = fetch_s1 && !cfg_we;

		done_leaf = pend_s1 && rd_data.is_leaf;
		to_root   = go_root_now || (pend_s1 && (rd_data.is_leaf || last_s1));
		step      = pend_s1 && !rd_data.is_leaf && !last_s1;

		walk_is_root = (slot(walk_q) == slot(root_q));
		next_is_root = (slot(next_s1) == slot(root_q));

		new_node.is_leaf = req.node_is_leaf;
		new_node.left    = req.left_child;
		new_node.right   = req.right_child;
		new_node.sym     = req.leaf_symbol;

		wr_en       = wr_acc;
		wr_hit_cur  = wr_acc && (slot(req.node_addr) == slot(walk_q));
		wr_hit_root = wr_acc && (slot(req.node_addr) == slot(root_q));

		rd_en   = issue || fetch;
		rd_addr = issue ? slot(next_idx) : slot(walk_q);
	end

	hbsd_ram #(
		.DATA_W ($bits(node_t)),
		.DEPTH  (NODE_COUNT)
	) u_node_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot(req.node_addr)),
		.wr_data (new_node),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign rd_data = node_t'(rd_raw);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q      <= '0;
			root_q      <= '0;
			cur_vld_q   <= 1'b0;
			root_vld_q  <= 1'b0;
			pend_s1     <= 1'b0;
			fetch_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cfg_we) begin
				// new root: both caches go stale, walk restarts there
				root_q     <= cfg_wdata;
				walk_q     <= cfg_wdata;
				cur_vld_q  <= 1'b0;
				root_vld_q <= 1'b0;
				fetch_s1   <= 1'b0;
			end else begin
				fetch_s1 <= fetch;
				if (to_root) begin
					walk_q    <= root_q;
					cur_vld_q <= root_vld_q;
				end else if (step) begin
					walk_q    <= next_s1;
					cur_vld_q <= 1'b1;
				end else if (fetch_done) begin
					cur_vld_q <= 1'b1;
				end
				if (wr_hit_root || (fetch_done && walk_is_root) ||
				    (step && next_is_root)) begin
					root_vld_q <= 1'b1;
				end
			end
			if (go_root_now || done_leaf) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (to_root) begin
			cur_q <= root_ent_q;
		end else if (step || fetch_done) begin
			cur_q <= rd_data;
		end else if (wr_hit_cur) begin
			cur_q <= new_node;
		end

		if (wr_hit_root) begin
			root_ent_q <= new_node;
		end else if ((fetch_done && walk_is_root) || (step && next_is_root)) begin
			root_ent_q <= rd_data;
		end

		if (issue) begin
			next_s1 <= next_idx;
			last_s1 <= req.last_bit;
		end

		if (go_root_now) begin
			rsp_q.symbol <= '0;
			rsp_q.status <= STATUS_EMPTY;
		end else if (done_leaf) begin
			rsp_q.symbol <= rd_data.sym;
			rsp_q.status <= STATUS_OK;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
